// File: rtl/core/matrix_multiply_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply engine
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_UNIT_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define MME_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mme assertion failed");

// antecedent implies consequent in the next cycle
`define MME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mme assertion failed");

`else

`define MME_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define MME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and constants of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int KIND_W  = 2;
    localparam int IDX_W   = 4;
    localparam int ELEM_W  = 16;
    localparam int MUL_W   = 2 * ELEM_W;
    localparam int PROD_W  = 38;
    localparam int ORDER_W = 5;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd16;

    // item kinds; the fourth code is ignored
    typedef enum logic [KIND_W-1:0] {
        KIND_WR_A  = 2'd0,
        KIND_WR_B  = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    // control travelling with the memory read data
    typedef struct packed {
        logic valid;
        logic last;
    } t_mac_ctl;

endpackage

// File: rtl/core/mme_if.sv
// ----------------------------------------------------------------------------
// mme_if
// Valid/ready channels: input items, result items and configuration writes.
// ----------------------------------------------------------------------------
interface mme_item_if;
    logic                                 valid;
    logic                                 ready;
    logic        [mme_pkg::KIND_W-1:0]    kind;
    logic        [mme_pkg::IDX_W-1:0]     row_index;
    logic        [mme_pkg::IDX_W-1:0]     col_index;
    logic signed [mme_pkg::ELEM_W-1:0]    element_value;

    modport source (output valid, kind, row_index, col_index, element_value, input ready);
    modport sink   (input valid, kind, row_index, col_index, element_value, output ready);
endinterface

interface mme_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mme_pkg::PROD_W-1:0]    product_value;
    logic        [mme_pkg::IDX_W-1:0]     out_row;
    logic        [mme_pkg::IDX_W-1:0]     out_col;

    modport source (output valid, product_value, out_row, out_col, input ready);
    modport sink   (input valid, product_value, out_row, out_col, output ready);
endinterface

interface mme_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic        [mme_pkg::ORDER_W-1:0]   matrix_order;

    modport source (output valid, matrix_order, input ready);
    modport sink   (input valid, matrix_order, output ready);
endinterface

// File: rtl/core/mme_ram.sv
// ----------------------------------------------------------------------------
// mme_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/mme_mac.sv
// ----------------------------------------------------------------------------
// mme_mac
// Multiply-accumulate: registered Q2.30 product of Q1.15 operands, then Q8.30 accumulator.
// ----------------------------------------------------------------------------
module mme_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clear,
    input  mme_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [mme_pkg::ELEM_W-1:0] i_a,
    input  logic signed [mme_pkg::ELEM_W-1:0] i_b,
    output logic signed [mme_pkg::PROD_W-1:0] o_acc,
    output logic                              o_done
);

    logic signed [mme_pkg::MUL_W-1:0]  r_prod;
    logic signed [mme_pkg::PROD_W-1:0] r_acc;
    mme_pkg::t_mac_ctl                 r_pctl;
    logic                              r_done;

    // control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pctl <= '0;
            r_done <= 1'b0;
        end else begin
            r_pctl <= i_ctl;
            r_done <= r_pctl.valid && r_pctl.last;
        end
    end

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // accumulate stage, cleared as a query starts
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_pctl.valid) begin
            r_acc <= r_acc + mme_pkg::PROD_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

// File: rtl/core/matrix_multiply_engine_unit.sv
// An accepted query walks n terms, n being the active order (min of matrix_order and
// MAX_ORDER), with one A/B memory read pair and one multiply-accumulate per term,
// then waits in S_PUSH until the output register is free; an empty sum goes straight
// to S_PUSH. Items are accepted only in S_IDLE, so a new word waits for the query.
// Reset: control and matrix_order (to 16) are cleared; element stores are not.
// ----------------------------------------------------------------------------
// matrix_multiply_engine_unit
// Square fixed-point matrix multiply: element stores for A and B, and a
// sequencer that walks one row of A and one column of B through a MAC.
// ----------------------------------------------------------------------------
`include "matrix_multiply_engine_unit_macros.svh"

module matrix_multiply_engine_unit #(
    parameter int MAX_ORDER = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mme_item_if.sink     i_item,
    mme_cfg_if.sink      i_cfg,
    mme_result_if.source o_result
);

    localparam int IW    = $clog2(MAX_ORDER);
    localparam int CELLS = MAX_ORDER * MAX_ORDER;
    localparam int CW    = $clog2(CELLS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_PUSH
    } t_state;

    t_state                              r_state, n_state;
    logic [mme_pkg::ORDER_W-1:0]         r_order;
    logic [IW-1:0]                       r_k, r_k_last;
    logic [CW-1:0]                       r_a_addr, r_b_addr;
    logic [mme_pkg::IDX_W-1:0]           r_row, r_col;
    mme_pkg::t_mac_ctl                   r_iss;
    logic                                r_out_valid;
    logic signed [mme_pkg::PROD_W-1:0]   r_out_prod;
    logic [mme_pkg::IDX_W-1:0]           r_out_row, r_out_col;

    logic                                item_acc, query_acc, in_range, empty_sum;
    logic                                rd_en, out_load, wr_a, wr_b, mac_done;
    logic [31:0]                         ord_eff;
    logic [CW-1:0]                       wr_addr;
    logic [mme_pkg::ELEM_W-1:0]          a_data, b_data;
    logic signed [mme_pkg::PROD_W-1:0]   mac_acc;

    // handshakes
    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign item_acc     = i_item.valid && i_item.ready;
    assign query_acc    = item_acc && (i_item.kind == mme_pkg::KIND_QUERY);

    // decode of the incoming word
    assign in_range  = (32'(i_item.row_index) < MAX_ORDER)
                    && (32'(i_item.col_index) < MAX_ORDER);
    assign ord_eff   = (32'(r_order) > MAX_ORDER) ? MAX_ORDER : 32'(r_order);
    assign empty_sum = !in_range || (ord_eff == 32'd0);
    assign wr_addr   = CW'(32'(i_item.row_index) * MAX_ORDER + 32'(i_item.col_index));
    assign wr_a      = item_acc && in_range && (i_item.kind == mme_pkg::KIND_WR_A);
    assign wr_b      = item_acc && in_range && (i_item.kind == mme_pkg::KIND_WR_B);

    assign rd_en    = (r_state == S_ISSUE);
    assign out_load = (r_state == S_PUSH) && (!r_out_valid || o_result.ready);

    // element stores
    mme_ram #(.WIDTH(mme_pkg::ELEM_W), .DEPTH(CELLS)) u_store_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_a),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_item.element_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_a_addr),
        .o_rd_data (a_data)
    );

    mme_ram #(.WIDTH(mme_pkg::ELEM_W), .DEPTH(CELLS)) u_store_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_b),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_item.element_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_b_addr),
        .o_rd_data (b_data)
    );

    // multiply-accumulate
    mme_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (query_acc),
        .i_ctl   (r_iss),
        .i_a     (a_data),
        .i_b     (b_data),
        .o_acc   (mac_acc),
        .o_done  (mac_done)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (query_acc) begin
                    n_state = empty_sum ? S_PUSH : S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (r_k == r_k_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (mac_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, configuration and output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_order     <= mme_pkg::ORDER_RESET;
            r_iss       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iss.valid <= rd_en;
            r_iss.last  <= rd_en && (r_k == r_k_last);
            if (i_cfg.valid && i_cfg.ready) begin
                r_order <= i_cfg.matrix_order;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // address walk and result payload
    always_ff @(posedge i_clk) begin
        if (query_acc) begin
            r_row    <= i_item.row_index;
            r_col    <= i_item.col_index;
            r_k      <= '0;
            r_k_last <= IW'(ord_eff - 32'd1);
            r_a_addr <= CW'(32'(i_item.row_index) * MAX_ORDER);
            r_b_addr <= CW'(32'(i_item.col_index));
        end else if (rd_en) begin
            r_k      <= r_k + IW'(1);
            r_a_addr <= r_a_addr + CW'(1);
            r_b_addr <= CW'(32'(r_b_addr) + MAX_ORDER);
        end
        if (out_load) begin
            r_out_prod <= mac_acc;
            r_out_row  <= r_row;
            r_out_col  <= r_col;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.product_value = r_out_prod;
    assign o_result.out_row       = r_out_row;
    assign o_result.out_col       = r_out_col;

    // checks
    `MME_ASSERT_NEXT(a_query_start, i_clk, i_rst_n, query_acc && !empty_sum, r_state == S_ISSUE)
    `MME_ASSERT_NOW(a_done_in_wait, i_clk, i_rst_n, mac_done, r_state == S_WAIT)
    `MME_ASSERT_NOW(a_k_bound, i_clk, i_rst_n, r_state == S_ISSUE, r_k <= r_k_last)
    `MME_ASSERT_NEXT(a_push_hold, i_clk, i_rst_n,
        (r_state == S_PUSH) && r_out_valid && !o_result.ready, r_state == S_PUSH)

endmodule

// File: verif/mme_product_checker.sv
// ----------------------------------------------------------------------------
// mme_product_checker
// Watches the item, configuration and result channels of the matrix multiply
// engine, keeps its own copy of the A and B stores and the active order,
// works out each product word and compares it with what the engine returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mme_product_checker #(
    parameter int MAX_ORDER = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mme_item_if    item_mon,
    mme_cfg_if     cfg_mon,
    mme_result_if  result_mon,
    output int     o_fail_count,
    output int     o_pending
);

    localparam int CELLS = MAX_ORDER * MAX_ORDER;

    typedef struct packed {
        logic signed [mme_pkg::PROD_W-1:0] product_value;
        logic        [mme_pkg::IDX_W-1:0]  out_row;
        logic        [mme_pkg::IDX_W-1:0]  out_col;
    } t_product_word;

    logic [mme_pkg::ELEM_W-1:0]  a_cells [CELLS];
    logic [mme_pkg::ELEM_W-1:0]  b_cells [CELLS];
    logic [mme_pkg::ORDER_W-1:0] order_reg;
    t_product_word               expected_products [$];
    int                          fail_count;

    // exact dot product of row r of A and column c of B over the active order
    function automatic logic signed [mme_pkg::PROD_W-1:0] dot_product(
        input logic [mme_pkg::IDX_W-1:0] r,
        input logic [mme_pkg::IDX_W-1:0] c
    );
        longint acc;
        int     n;
        int     k;
        acc = 0;
        n = (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
        // indices past the built size give a zero word
        if (int'(r) < MAX_ORDER && int'(c) < MAX_ORDER) begin
            for (k = 0; k < n; k++) begin
                acc += longint'($signed(a_cells[int'(r) * MAX_ORDER + k]))
                     * longint'($signed(b_cells[k * MAX_ORDER + int'(c)]));
            end
        end
        return acc[mme_pkg::PROD_W-1:0];
    endfunction

    // track accepted words, predict and compare
    always @(posedge i_clk) begin
        t_product_word got;
        t_product_word want;
        if (!i_rst_n) begin
            order_reg = mme_pkg::ORDER_RESET;
            fail_count = 0;
            expected_products.delete();
            foreach (a_cells[i]) begin
                a_cells[i] = '0;
                b_cells[i] = '0;
            end
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) begin
                order_reg = cfg_mon.matrix_order;
            end

            // result side first: a word leaving now belongs to an earlier query
            if (result_mon.valid && result_mon.ready) begin
                got.product_value = result_mon.product_value;
                got.out_row       = result_mon.out_row;
                got.out_col       = result_mon.out_col;
                if (expected_products.size() == 0) begin
                    $error("product_value: word with no query outstanding, expected none, got %0d",
                           got.product_value);
                    fail_count++;
                end else begin
                    want = expected_products.pop_front();
                    if (got.product_value !== want.product_value) begin
                        $error("product_value mismatch: expected %0d, got %0d",
                               want.product_value, got.product_value);
                        fail_count++;
                    end
                    if (got.out_row !== want.out_row) begin
                        $error("out_row mismatch: expected %0d, got %0d",
                               want.out_row, got.out_row);
                        fail_count++;
                    end
                    if (got.out_col !== want.out_col) begin
                        $error("out_col mismatch: expected %0d, got %0d",
                               want.out_col, got.out_col);
                        fail_count++;
                    end
                end
            end

            if (item_mon.valid && item_mon.ready) begin
                case (item_mon.kind)
                    mme_pkg::KIND_WR_A: begin
                        if (int'(item_mon.row_index) < MAX_ORDER
                                && int'(item_mon.col_index) < MAX_ORDER) begin
                            a_cells[int'(item_mon.row_index) * MAX_ORDER
                                    + int'(item_mon.col_index)] = item_mon.element_value;
                        end
                    end
                    mme_pkg::KIND_WR_B: begin
                        if (int'(item_mon.row_index) < MAX_ORDER
                                && int'(item_mon.col_index) < MAX_ORDER) begin
                            b_cells[int'(item_mon.row_index) * MAX_ORDER
                                    + int'(item_mon.col_index)] = item_mon.element_value;
                        end
                    end
                    mme_pkg::KIND_QUERY: begin
                        want.product_value = dot_product(item_mon.row_index,
                                                         item_mon.col_index);
                        want.out_row       = item_mon.row_index;
                        want.out_col       = item_mon.col_index;
                        expected_products.push_back(want);
                    end
                    default: begin
                        // unused kind: dropped by the engine
                    end
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_products.size();
    end

endmodule

// File: verif/tb_matrix_multiply_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_matrix_multiply_engine_unit
// Drives element writes and product queries into the matrix multiply engine
// through a run of matrix orders (zero, one, the built size and above), with
// bursty input and a stalling result sink; the checker beside the engine
// predicts every product word and counts mismatches for the verdict here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_matrix_multiply_engine_unit;

    localparam int MAX_ORDER     = 16;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 2 * MAX_ORDER + 8;
    localparam int PHASE_WORDS   = 170;

    // fourth kind code, ignored by the engine
    localparam logic [mme_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        SINK_FREE,
        SINK_COIN,
        SINK_SLOW,
        SINK_RARE
    } t_sink_mode;

    logic i_clk;
    logic i_rst_n;

    mme_item_if   item_ch ();
    mme_cfg_if    cfg_ch ();
    mme_result_if result_ch ();

    int                          fail_count;
    int                          pending_count;
    int                          cycle_count = 0;
    int                          burst_left;
    int                          sink_tick;
    t_sink_mode                  sink_mode;
    logic [mme_pkg::ORDER_W-1:0] order_now;
    bit                          a_written [MAX_ORDER][MAX_ORDER];
    bit                          b_written [MAX_ORDER][MAX_ORDER];

    matrix_multiply_engine_unit #(
        .MAX_ORDER (MAX_ORDER)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    mme_product_checker #(
        .MAX_ORDER (MAX_ORDER)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .item_mon     (item_ch),
        .cfg_mon      (cfg_ch),
        .result_mon   (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result sink: stall pattern re-picked at random periodically
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            sink_tick       <= 0;
            sink_mode       <= SINK_FREE;
        end else begin
            sink_tick <= sink_tick + 1;
            if (sink_tick % 150 == 0) begin
                sink_mode <= t_sink_mode'($urandom_range(0, 3));
            end
            case (sink_mode)
                SINK_FREE: result_ch.ready <= 1'b1;
                SINK_COIN: result_ch.ready <= 1'($urandom_range(0, 1));
                SINK_SLOW: result_ch.ready <= (sink_tick % 6 == 0);
                default:   result_ch.ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    function automatic int active_order();
        return (order_now > MAX_ORDER) ? MAX_ORDER : int'(order_now);
    endfunction

    // element values lean on the Q1.15 extremes now and then
    function automatic logic [mme_pkg::ELEM_W-1:0] pick_element();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // one word into the engine; bursts of random length, random gaps between
    task automatic send_word(input logic [mme_pkg::KIND_W-1:0] k,
                             input logic [mme_pkg::IDX_W-1:0]  r,
                             input logic [mme_pkg::IDX_W-1:0]  c,
                             input logic [mme_pkg::ELEM_W-1:0] v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        item_ch.valid         <= 1'b1;
        item_ch.kind          <= k;
        item_ch.row_index     <= r;
        item_ch.col_index     <= c;
        item_ch.element_value <= v;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        burst_left--;
        if (k == mme_pkg::KIND_WR_A) begin
            a_written[r][c] = 1'b1;
        end else if (k == mme_pkg::KIND_WR_B) begin
            b_written[r][c] = 1'b1;
        end
    endtask

    // stop input, wait for the last product word and let the engine settle
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_order(input logic [mme_pkg::ORDER_W-1:0] v);
        wait_drained();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.matrix_order <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        order_now  = v;
        burst_left = 0;
    endtask

    // random word; counted is cleared for the ignored kind
    task automatic random_word(output bit counted);
        int                         roll;
        int                         n;
        int                         k;
        bit                         fixed;
        logic [mme_pkg::IDX_W-1:0]  r;
        logic [mme_pkg::IDX_W-1:0]  c;
        roll    = $urandom_range(0, 99);
        r       = 4'($urandom_range(0, 15));
        c       = 4'($urandom_range(0, 15));
        counted = 1'b1;
        if (roll < 3) begin
            send_word(KIND_UNUSED, r, c, 16'($urandom));
            counted = 1'b0;
        end else if (roll < 30) begin
            send_word(mme_pkg::KIND_WR_A, r, c, pick_element());
        end else if (roll < 57) begin
            send_word(mme_pkg::KIND_WR_B, r, c, pick_element());
        end else begin
            // a query touching a never-written cell becomes the missing write
            n     = active_order();
            fixed = 1'b0;
            for (k = 0; k < n && !fixed; k++) begin
                if (!a_written[r][k]) begin
                    send_word(mme_pkg::KIND_WR_A, r, 4'(k), pick_element());
                    fixed = 1'b1;
                end else if (!b_written[k][c]) begin
                    send_word(mme_pkg::KIND_WR_B, 4'(k), c, pick_element());
                    fixed = 1'b1;
                end
            end
            if (!fixed) begin
                send_word(mme_pkg::KIND_QUERY, r, c, 16'($urandom));
            end
        end
    endtask

    task automatic run_phase(input logic [mme_pkg::ORDER_W-1:0] ord);
        int done;
        bit counted;
        write_order(ord);
        done = 0;
        while (done < PHASE_WORDS) begin
            random_word(counted);
            if (counted) begin
                done++;
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n               = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.kind          = mme_pkg::KIND_WR_A;
        item_ch.row_index     = '0;
        item_ch.col_index     = '0;
        item_ch.element_value = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.matrix_order   = mme_pkg::ORDER_RESET;
        result_ch.ready       = 1'b0;
        order_now             = mme_pkg::ORDER_RESET;
        burst_left            = 0;
        foreach (a_written[i, j]) begin
            a_written[i][j] = 1'b0;
            b_written[i][j] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // order zero: empty sums, nothing needs writing
        write_order(5'd0);
        send_word(mme_pkg::KIND_QUERY, 4'd0, 4'd0, 16'h0000);
        send_word(mme_pkg::KIND_QUERY, 4'd15, 4'd15, 16'hFFFF);
        send_word(KIND_UNUSED, 4'd15, 4'd15, 16'hFFFF);

        // order one: extreme products at the corners
        write_order(5'd1);
        send_word(mme_pkg::KIND_WR_A, 4'd0, 4'd0, 16'h8000);
        send_word(mme_pkg::KIND_WR_B, 4'd0, 4'd0, 16'h8000);
        send_word(mme_pkg::KIND_QUERY, 4'd0, 4'd0, 16'h0000);
        send_word(mme_pkg::KIND_WR_A, 4'd15, 4'd0, 16'h7FFF);
        send_word(mme_pkg::KIND_WR_B, 4'd0, 4'd15, 16'h7FFF);
        send_word(mme_pkg::KIND_QUERY, 4'd15, 4'd15, 16'h0000);
        send_word(mme_pkg::KIND_QUERY, 4'd0, 4'd15, 16'h0000);
        send_word(mme_pkg::KIND_QUERY, 4'd15, 4'd0, 16'h0000);
        // cells past the order are stored but take no part in the sum
        send_word(mme_pkg::KIND_WR_A, 4'd15, 4'd15, 16'hFFFF);
        send_word(mme_pkg::KIND_WR_B, 4'd15, 4'd15, 16'h0001);
        send_word(mme_pkg::KIND_QUERY, 4'd15, 4'd15, 16'hFFFF);

        // random phases across the order range, above the built size too
        run_phase(5'd16);
        run_phase(5'd31);
        run_phase(5'd1);
        run_phase(5'd17);
        run_phase(5'd2);
        run_phase(5'($urandom_range(3, 15)));
        run_phase(5'd0);
        run_phase(5'($urandom));
        run_phase(5'd16);

        wait_drained();
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/mme_pkg.sv
rtl/core/mme_if.sv
rtl/core/mme_ram.sv
rtl/core/mme_mac.sv
rtl/core/matrix_multiply_engine_unit.sv
verif/mme_product_checker.sv
verif/tb_matrix_multiply_engine_unit.sv
